// ===== rtl/okvt_pkg.sv =====
// Shared types and codes for the ordered key/value table.
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int OP_W  = 3;
    localparam int LIVE_OUT_W = 5;

    localparam logic [OP_W-1:0] OP_SET = 3'd0;
    localparam logic [OP_W-1:0] OP_GET = 3'd1;
    localparam logic [OP_W-1:0] OP_HAS = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL = 3'd3;
    localparam logic [OP_W-1:0] OP_CLR = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic latch;        // take the input item
        logic clr_idx;      // restart scan at slot 0
        logic inc_idx;      // next slot
        logic commit_hit;   // act on matched slot
        logic commit_miss;  // act with no match (append, full, clear, unknown)
        logic load_out;     // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_needed;  // input op looks up and table has slots
        logic hit;          // slot read back is live and matches
        logic last;         // current slot is the last used one
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/ordered_key_value_table.sv =====
// Top level of the insertion-ordered key/value table with tombstones.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+----------------------------------------
//   input    | i_in_valid / o_in_ready   | i_operation, i_key, i_value
//   output   | o_out_valid / i_out_ready | o_found, o_read_value, o_live_count,
//            |                           | o_table_full
//
// Flow: one item at a time. Clear, unknown codes and lookups on an empty
//   table skip the scan and commit as a miss. A lookup scans the slots in use
//   (at most CAPACITY) in order and stops at the first live match; the scan
//   reads the slots one at a time through the registered read port of the
//   key and value RAMs.
// Reset: synchronous, active low; clears the fill count, the live count, the
//   controller and the output valid. The RAMs are not cleared: only slots
//   below the fill count are ever read, and each of those was written.
// Stalls: the result sits in an output register; a new item is taken once the
//   previous result has moved there, even while it waits on i_out_ready.
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_value_table
    import okvt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [OP_W-1:0]         i_operation,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_found,
    output logic signed [VAL_W-1:0]      o_read_value,
    output logic [LIVE_OUT_W-1:0]        o_live_count,
    output logic                         o_table_full
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing: accept, scan slots in order, commit, hand off result
    okvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // stores, counters, compare and result registers
    okvt_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_live_count (o_live_count),
        .o_table_full (o_table_full)
    );

endmodule

`default_nettype wire

// ===== rtl/okvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module okvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wen,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/okvt_dp.sv =====
// Datapath: operand latch, slot scan index, counters, stores and result registers.
`timescale 1ns / 1ps
`default_nettype none

module okvt_dp
    import okvt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_status,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic signed [KEY_W-1:0]  i_key,
    input  wire logic signed [VAL_W-1:0]  i_value,
    output logic                          o_found,
    output logic signed [VAL_W-1:0]       o_read_value,
    output logic [LIVE_OUT_W-1:0]         o_live_count,
    output logic                          o_table_full
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [OP_W-1:0]         r_op;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [IDX_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_slots, n_slots;
    logic [CNT_W-1:0]        r_live, n_live;
    logic                    r_found;
    logic [VAL_W-1:0]        r_rd;
    logic                    r_full;

    logic [KEY_W:0]          w_kdata;   // {tombstone, key}
    logic [VAL_W-1:0]        w_vdata;
    logic                    w_key_wen, w_val_wen;
    logic [IDX_W-1:0]        w_waddr;
    logic                    w_has_room;
    logic                    w_is_lookup;
    logic [31:0]             w_live_ext;

    assign w_is_lookup = (i_operation == OP_SET) || (i_operation == OP_GET)
                      || (i_operation == OP_HAS) || (i_operation == OP_DEL);
    assign w_has_room  = (r_slots != CNT_W'(CAPACITY));

    assign o_status.scan_needed = w_is_lookup && (r_slots != '0);
    assign o_status.hit  = !w_kdata[KEY_W] && (w_kdata[KEY_W-1:0] == r_key);
    assign o_status.last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_slots);

    // store writes: hit updates in place, miss appends at the fill count
    always_comb begin
        w_key_wen = 1'b0;
        w_val_wen = 1'b0;
        w_waddr   = r_slots[IDX_W-1:0];
        if (i_cmd.commit_hit) begin
            w_waddr   = r_idx;
            w_key_wen = (r_op == OP_DEL);
            w_val_wen = (r_op == OP_SET);
        end else if (i_cmd.commit_miss && r_op == OP_SET && w_has_room) begin
            w_key_wen = 1'b1;
            w_val_wen = 1'b1;
        end
    end

    okvt_ram #(.WIDTH(KEY_W + 1), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_wen   (w_key_wen),
        .i_waddr (w_waddr),
        .i_wdata ({i_cmd.commit_hit, r_key}),
        .i_raddr (r_idx),
        .o_rdata (w_kdata)
    );

    okvt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_wen   (w_val_wen),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_raddr (r_idx),
        .o_rdata (w_vdata)
    );

    always_comb begin
        n_slots = r_slots;
        n_live  = r_live;
        if (i_cmd.commit_hit && r_op == OP_DEL && r_live != '0) begin
            n_live = r_live - CNT_W'(1);
        end else if (i_cmd.commit_miss) begin
            if (r_op == OP_CLR) begin
                n_slots = '0;
                n_live  = '0;
            end else if (r_op == OP_SET && w_has_room) begin
                n_slots = r_slots + CNT_W'(1);
                n_live  = r_live + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
            r_live  <= '0;
            r_idx   <= '0;
        end else begin
            r_slots <= n_slots;
            r_live  <= n_live;
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    assign w_live_ext = 32'(r_live);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_operation;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.commit_hit) begin
            r_found <= 1'b1;
            r_rd    <= (r_op == OP_GET) ? w_vdata : '0;
            r_full  <= 1'b0;
        end else if (i_cmd.commit_miss) begin
            r_found <= 1'b0;
            r_rd    <= '0;
            r_full  <= (r_op == OP_SET) && !w_has_room;
        end
        if (i_cmd.load_out) begin
            o_found      <= r_found;
            o_read_value <= r_rd;
            o_live_count <= w_live_ext[LIVE_OUT_W-1:0];
            o_table_full <= r_full;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/okvt_ctrl.sv =====
// Controller: sequences accept, slot scan, commit and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module okvt_ctrl
    import okvt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REQ  = 5'b00010,
        S_CHK  = 5'b00100,
        S_MISS = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_state = i_status.scan_needed ? S_REQ : S_MISS;
                end
            end
            S_REQ: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_status.hit) begin
                    o_cmd.commit_hit = 1'b1;
                    n_state = S_EMIT;
                end else if (i_status.last) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state = S_REQ;
                end
            end
            S_MISS: begin
                o_cmd.commit_miss = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== tb/okvt_checker.sv =====
// Watches both channels of the key/value table, predicts each result and compares.
`timescale 1ns / 1ps

module okvt_checker
    import okvt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [KEY_W-1:0]        i_key,
    input  logic [VAL_W-1:0]        i_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_found,
    input  logic [VAL_W-1:0]        i_read_value,
    input  logic [LIVE_OUT_W-1:0]   i_live_count,
    input  logic                    i_table_full,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic                  found;
        logic [VAL_W-1:0]      read_value;
        logic [LIVE_OUT_W-1:0] live_count;
        logic                  table_full;
    } t_table_reply;

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_key  [CAPACITY];
    logic [VAL_W-1:0] shadow_val  [CAPACITY];
    logic             shadow_tomb [CAPACITY];
    int               shadow_fill;
    int               shadow_live;

    t_table_reply replies_due[$];
    int           mismatches;

    task automatic apply_table_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                  input logic [VAL_W-1:0] v, output t_table_reply reply);
        int hit_idx;
        hit_idx = -1;
        reply   = '0;
        if (op <= OP_DEL) begin
            for (int i = 0; i < shadow_fill; i++) begin
                if (hit_idx < 0 && !shadow_tomb[i] && shadow_key[i] == k) begin
                    hit_idx = i;
                end
            end
            reply.found = (hit_idx >= 0);
        end
        case (op)
            OP_SET: begin
                if (hit_idx >= 0) begin
                    shadow_val[hit_idx] = v;
                end else if (shadow_fill < CAPACITY) begin
                    shadow_key[shadow_fill]  = k;
                    shadow_val[shadow_fill]  = v;
                    shadow_tomb[shadow_fill] = 1'b0;
                    shadow_fill++;
                    shadow_live++;
                end else begin
                    reply.table_full = 1'b1;
                end
            end
            OP_GET: begin
                if (hit_idx >= 0) begin
                    reply.read_value = shadow_val[hit_idx];
                end
            end
            OP_DEL: begin
                if (hit_idx >= 0) begin
                    shadow_tomb[hit_idx] = 1'b1;
                    if (shadow_live > 0) begin
                        shadow_live--;
                    end
                end
            end
            OP_CLR: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    shadow_tomb[i] = 1'b0;
                end
                shadow_fill = 0;
                shadow_live = 0;
            end
            default: ;  // has, and unused codes: no change
        endcase
        reply.live_count = shadow_live[LIVE_OUT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_table_reply want;
        t_table_reply got;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                shadow_tomb[i] = 1'b0;
            end
            shadow_fill = 0;
            shadow_live = 0;
            mismatches  = 0;
            replies_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_found, i_read_value, i_live_count, i_table_full};
                if (replies_due.size() == 0) begin
                    $display("%0t: result with none pending: found=%0b rd=%h live=%0d full=%0b",
                             $time, got.found, got.read_value, got.live_count, got.table_full);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, got.found);
                        mismatches++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, got.read_value);
                        mismatches++;
                    end
                    if (got.live_count !== want.live_count) begin
                        $display("%0t: live_count expected %0d actual %0d",
                                 $time, want.live_count, got.live_count);
                        mismatches++;
                    end
                    if (got.table_full !== want.table_full) begin
                        $display("%0t: table_full expected %0b actual %0b",
                                 $time, want.table_full, got.table_full);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_table_op(i_operation, i_key, i_value, want);
                // append at the tail, oldest reply stays at the head
                replies_due.insert(replies_due.size(), want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= replies_due.size();
    end

endmodule

// ===== tb/ordered_key_value_table_test.sv =====
// Stimulus and verdict for the ordered key/value table, with the checker beside it.
`timescale 1ns / 1ps

module ordered_key_value_table_test;
    import okvt_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 600000;
    // drain margin covers four worst-case scans, each a miss over every slot
    localparam int DRAIN_CYCLES = 4 * (2 * CAPACITY + 3);
    // window of items with no idling on either side
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 900;
    // long receiver hold-off so results back up and the input stalls
    localparam int HOLD_AT      = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 15;

    // codes the block must treat as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MD = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       operation;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic                  out_valid;
    logic                  out_ready;
    logic                  found;
    logic [VAL_W-1:0]      read_value;
    logic [LIVE_OUT_W-1:0] live_count;
    logic                  table_full;

    int fail_count;
    int pending;
    int items_sent;
    int cycle_count;

    ordered_key_value_table #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_operation  (operation),
        .i_key        (key),
        .i_value      (value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_found      (found),
        .o_read_value (read_value),
        .o_live_count (live_count),
        .o_table_full (table_full)
    );

    okvt_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_operation  (operation),
        .i_key        (key),
        .i_value      (value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_found      (found),
        .i_read_value (read_value),
        .i_live_count (live_count),
        .i_table_full (table_full),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop if the run hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random word, now and then one of the corner values
    function automatic logic [63:0] pick_word();
        case ($urandom_range(11))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            3:       return ALL_ONES;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] spare_op();
        return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    function automatic bit quiet_window();
        return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
    endfunction

    // Present one item; entered and left at a falling edge. Valid stays up
    // straight into the next item unless a gap is drawn.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
        while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        value     <= v;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    // Well-formed traffic over a small key pool, larger than the table, so
    // hits, misses, tombstones and full drops all show up.
    task automatic mixed_run();
        logic [KEY_W-1:0] pool [20];
        int               n;
        int               r;
        logic [KEY_W-1:0] k;
        foreach (pool[i]) begin
            pool[i] = pick_word();
        end
        n = $urandom_range(8, 30);
        repeat (n) begin
            k = pool[$urandom_range(19)];
            r = $urandom_range(99);
            if (r < 40) begin
                send_item(OP_SET, k, pick_word());
            end else if (r < 62) begin
                send_item(OP_GET, k, rand64());
            end else if (r < 77) begin
                send_item(OP_HAS, k, rand64());
            end else if (r < 93) begin
                send_item(OP_DEL, k, rand64());
            end else if (r < 96) begin
                send_item(OP_CLR, rand64(), rand64());
            end else begin
                send_item(spare_op(), k, rand64());
            end
        end
    endtask

    // Clear, then append past capacity so the last sets are dropped, then
    // touch the stored keys while the table is full.
    task automatic fill_run();
        logic [KEY_W-1:0] stored [CAPACITY + 3];
        int               r;
        send_item(OP_CLR, rand64(), rand64());
        foreach (stored[i]) begin
            stored[i] = rand64();
            send_item(OP_SET, stored[i], pick_word());
        end
        repeat ($urandom_range(4, 10)) begin
            r = $urandom_range(CAPACITY + 2);
            case ($urandom_range(3))
                0:       send_item(OP_SET, stored[r], pick_word());
                1:       send_item(OP_DEL, stored[r], rand64());
                2:       send_item(OP_HAS, stored[r], rand64());
                default: send_item(OP_GET, stored[r], rand64());
            endcase
        end
    endtask

    // Unstructured items, any code.
    task automatic noise_run();
        repeat ($urandom_range(4, 12)) begin
            send_item(OP_W'($urandom_range((1 << OP_W) - 1)), pick_word(), pick_word());
        end
    endtask

    // Receiver: random stalls, a quiet window, and one long hold-off.
    initial begin
        int  hold_left;
        bit  held_once;
        logic ready_next;
        hold_left = 0;
        held_once = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (!held_once && items_sent >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (quiet_window()) begin
                ready_next = 1'b1;
            end else begin
                ready_next = ($urandom_range(99) >= IDLE_PCT);
            end
            out_ready <= ready_next;
        end
    end

    initial begin
        int r;
        items_sent = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_CLR;
        key       <= '0;
        value     <= '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, extreme keys and values, update, tombstone,
        // delete of an absent key, append after a tombstone, spare codes
        send_item(OP_CLR, '0, '0);
        send_item(OP_GET, '0, '0);
        send_item(OP_HAS, '0, '0);
        send_item(OP_DEL, '0, '0);
        send_item(OP_SET, MOST_NEG, MOST_POS);
        send_item(OP_SET, MOST_POS, MOST_NEG);
        send_item(OP_SET, '0, ALL_ONES);
        send_item(OP_GET, MOST_NEG, '0);
        send_item(OP_GET, MOST_POS, '0);
        send_item(OP_HAS, MOST_POS, '0);
        send_item(OP_SET, MOST_NEG, '0);
        send_item(OP_GET, MOST_NEG, '0);
        send_item(OP_DEL, MOST_NEG, '0);
        send_item(OP_GET, MOST_NEG, '0);
        send_item(OP_HAS, MOST_NEG, '0);
        send_item(OP_DEL, MOST_NEG, '0);
        send_item(OP_SET, MOST_NEG, 64'd1);
        send_item(OP_GET, MOST_NEG, ALL_ONES);
        send_item(OP_SPARE_LO, MOST_POS, ALL_ONES);
        send_item(OP_SPARE_MD, MOST_POS, ALL_ONES);
        send_item(OP_SPARE_HI, ALL_ONES, ALL_ONES);
        send_item(OP_GET, '0, '0);
        send_item(OP_CLR, ALL_ONES, ALL_ONES);
        send_item(OP_GET, MOST_POS, '0);

        // random: mostly structured traffic, some full-table runs, some noise
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 60) begin
                mixed_run();
            end else if (r < 82) begin
                fill_run();
            end else begin
                noise_run();
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/okvt_pkg.sv
rtl/okvt_ram.sv
rtl/okvt_dp.sv
rtl/okvt_ctrl.sv
rtl/ordered_key_value_table.sv
tb/okvt_checker.sv
tb/ordered_key_value_table_test.sv
